FILE: hdl/look_at_view_matrix_top_assert.svh
// Assertion macros for the look-at view matrix block.
`ifndef LOOK_AT_VIEW_MATRIX_TOP_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_TOP_ASSERT_SVH

// Same-cycle implication, gated by the active-low reset.
`define LAM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("look-at matrix check failed");

// Next-cycle implication, gated by the active-low reset.
`define LAM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("look-at matrix sequence check failed");

`endif

FILE: hdl/lam_pkg.sv
package lam_pkg;

    // one input transaction
    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] up_hint_x;
        logic signed [31:0] up_hint_y;
        logic signed [31:0] up_hint_z;
    } t_in_item;

    // one result transaction (one matrix row)
    typedef struct packed {
        logic signed [31:0] elem_first;
        logic signed [31:0] elem_second;
        logic signed [31:0] elem_third;
        logic [1:0]         row_index;
        logic               degenerate;
        logic               last_row;
    } t_out_item;

    // queued job: eye, up hint, exact direction and its zero class
    typedef struct packed {
        logic [2:0][31:0] eye;
        logic [2:0][31:0] up;
        logic [2:0][32:0] dir;
        logic             dir_zero;
    } t_job;

    // normalizer status
    typedef struct packed {
        logic done;
        logic zero;
    } t_norm_sts;

    localparam logic [1:0] ROW_FIRST = 2'd0;
    localparam logic [1:0] ROW_TRANS = 2'd3;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

endpackage

FILE: hdl/look_at_view_matrix_top.sv
// Left-handed look-at view matrix in signed fixed point with FRAC_BITS fraction
// bits. A transaction is taken on a clock edge with start high and busy low; it
// carries eye, target and up hint. For each one the block emits four rows on
// o_res_strobe, one per cycle on consecutive cycles: rows 0..2 are
// (right, true up, forward) per axis, row 3 the saturated translation. The
// receiver cannot stall, so every row appears exactly once for one cycle.
// A front stage forms target - eye and flags a zero direction; a queue of
// QUEUE_DEPTH jobs feeds the back end, so new transactions are taken while a
// matrix is still being built. The back end takes one job at a time; its
// normalizations run on the shared normalizer: a one-bit-per-cycle scaling
// shift, a 32-step square root and three bit-serial divides of FRAC_BITS + 2
// steps, run once for forward and once for right. A zero direction skips all
// of this and goes straight to its four zero rows.
module look_at_view_matrix_top #(
    parameter int FRAC_BITS   = 16,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  lam_pkg::t_in_item  i_item,
    output logic               o_res_strobe,
    output lam_pkg::t_out_item o_res
);

    // front -> queue
    logic          push;
    lam_pkg::t_job front_job;
    // queue -> back
    logic          pop;
    logic          q_full;
    logic          q_empty;
    lam_pkg::t_job head_job;
    // back <-> normalizer
    logic                      nstart;
    logic [2:0][63:0]          nv;
    lam_pkg::t_norm_sts        nsts;
    logic [2:0][FRAC_BITS+1:0] nq;

    lam_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_item  (i_item),
        .i_full  (q_full),
        .o_push  (push),
        .o_job   (front_job)
    );

    lam_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // one normalizer, used for forward and then for right
    lam_norm #(
        .FRAC_BITS (FRAC_BITS)
    ) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (nstart),
        .i_v     (nv),
        .o_sts   (nsts),
        .o_q     (nq)
    );

    // sequencer: cross products and dots on one 32x32 multiplier, row output
    lam_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .i_job        (head_job),
        .o_pop        (pop),
        .o_nstart     (nstart),
        .o_nv         (nv),
        .i_nsts       (nsts),
        .i_nq         (nq),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res)
    );

endmodule

FILE: hdl/lam_front.sv
module lam_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  lam_pkg::t_in_item i_item,
    input  logic              i_full,
    output logic              o_push,
    output lam_pkg::t_job     o_job
);

    logic          r_vld;
    lam_pkg::t_job r_job;
    lam_pkg::t_job n_job;
    logic          accept;

    // exact 33-bit direction, zero direction flagged for the fast path
    always_comb begin
        n_job          = r_job;
        n_job.eye[0]   = i_item.eye_x;
        n_job.eye[1]   = i_item.eye_y;
        n_job.eye[2]   = i_item.eye_z;
        n_job.up[0]    = i_item.up_hint_x;
        n_job.up[1]    = i_item.up_hint_y;
        n_job.up[2]    = i_item.up_hint_z;
        n_job.dir[0]   = {i_item.target_x[31], i_item.target_x}
                       - {i_item.eye_x[31], i_item.eye_x};
        n_job.dir[1]   = {i_item.target_y[31], i_item.target_y}
                       - {i_item.eye_y[31], i_item.eye_y};
        n_job.dir[2]   = {i_item.target_z[31], i_item.target_z}
                       - {i_item.eye_z[31], i_item.eye_z};
        n_job.dir_zero = (i_item.target_x == i_item.eye_x)
                       && (i_item.target_y == i_item.eye_y)
                       && (i_item.target_z == i_item.eye_z);
    end

    assign o_push = r_vld & ~i_full;
    assign o_busy = r_vld & i_full;
    assign accept = i_start & ~o_busy;
    assign o_job  = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= accept | (r_vld & ~o_push);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= n_job;
        end
    end

endmodule

FILE: hdl/lam_fifo.sv
module lam_fifo #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lam_pkg::t_job i_job,
    input  logic          i_pop,
    output lam_pkg::t_job o_job,
    output logic          o_full,
    output logic          o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    lam_pkg::t_job r_q [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;
            end
            priority if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end else begin
                r_cnt <= r_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_job;
        end
    end

endmodule

FILE: hdl/lam_norm.sv
module lam_norm #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [2:0][63:0]              i_v,
    output lam_pkg::t_norm_sts            o_sts,
    output logic [2:0][FRAC_BITS+1:0]     o_q
);

    localparam int QB  = FRAC_BITS + 2;
    localparam int BCW = $clog2(QB);

    typedef enum logic [2:0] {
        S_IDLE, S_MAX, S_SCALE, S_SQ, S_SQRT, S_DLD, S_DIV, S_DONE
    } t_state;

    t_state            r_state;
    logic [62:0]       r_m [3];
    logic [2:0]        r_neg;
    logic [62:0]       r_mx;
    logic [1:0]        r_cnt;
    logic [59:0]       r_prod;
    logic [63:0]       r_n;
    logic [63:0]       r_res;
    logic [4:0]        r_j;
    logic [63:0]       r_rem;
    logic [63:0]       r_dsh;
    logic [QB-1:0]     r_qt;
    logic [BCW-1:0]    r_bc;
    logic [1:0]        r_ci;
    logic              r_zero;
    logic [2:0][QB-1:0] r_q;

    logic [62:0] mag [3];
    logic [62:0] mx01;
    logic [62:0] mx;
    logic [29:0] sq_op;
    logic [62:0] m_ci;
    logic        neg_ci;
    logic [63:0] bitv;
    logic [63:0] trial;
    logic [63:0] num;
    logic        ge;
    logic [QB-1:0] qnext;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag[i] = i_v[i][63] ? 63'(64'd0 - i_v[i]) : i_v[i][62:0];
        end
        mx01 = (r_m[0] > r_m[1]) ? r_m[0] : r_m[1];
        mx   = (mx01 > r_m[2]) ? mx01 : r_m[2];

        unique case (r_cnt)
            2'd0:    sq_op = r_m[0][29:0];
            2'd1:    sq_op = r_m[1][29:0];
            2'd2:    sq_op = r_m[2][29:0];
            default: sq_op = '0;
        endcase

        unique case (r_ci)
            2'd0:    begin m_ci = r_m[0]; neg_ci = r_neg[0]; end
            2'd1:    begin m_ci = r_m[1]; neg_ci = r_neg[1]; end
            2'd2:    begin m_ci = r_m[2]; neg_ci = r_neg[2]; end
            default: begin m_ci = '0;     neg_ci = 1'b0;     end
        endcase

        bitv  = 64'd1 << {r_j, 1'b0};
        trial = r_res + bitv;
        num   = (64'(m_ci) << FRAC_BITS) + (r_res >> 1);
        ge    = (r_rem >= r_dsh);
        qnext = {r_qt[QB-2:0], ge};
    end

    assign o_sts.done = (r_state == S_DONE);
    assign o_sts.zero = r_zero;
    assign o_q        = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        for (int i = 0; i < 3; i++) begin
                            r_m[i]   <= mag[i];
                            r_neg[i] <= i_v[i][63];
                        end
                        r_state <= S_MAX;
                    end
                end
                S_MAX: begin
                    r_mx <= mx;
                    if (mx == '0) begin
                        r_zero  <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_zero  <= 1'b0;
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    // bring the largest magnitude into [2^29, 2^30), one bit a cycle
                    priority if (r_mx[62:29] == '0) begin
                        r_mx <= r_mx << 1;
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 1;
                    end else if (r_mx[62:30] != '0) begin
                        r_mx <= r_mx >> 1;
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
                    end else begin
                        r_cnt   <= '0;
                        r_n     <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_prod <= sq_op * sq_op;
                    if (r_cnt != '0) begin
                        r_n <= r_n + 64'(r_prod);
                    end
                    if (r_cnt == 2'd3) begin
                        r_res   <= '0;
                        r_j     <= 5'd31;
                        r_state <= S_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_SQRT: begin
                    if (r_n >= trial) begin
                        r_n   <= r_n - trial;
                        r_res <= (r_res >> 1) + bitv;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    if (r_j == '0) begin
                        r_ci    <= '0;
                        r_state <= S_DLD;
                    end else begin
                        r_j <= r_j - 1'b1;
                    end
                end
                S_DLD: begin
                    r_rem   <= num;
                    r_dsh   <= r_res << (QB - 1);
                    r_qt    <= '0;
                    r_bc    <= BCW'(QB - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (ge) begin
                        r_rem <= r_rem - r_dsh;
                    end
                    r_qt  <= qnext;
                    r_dsh <= r_dsh >> 1;
                    if (r_bc == '0) begin
                        for (int i = 0; i < 3; i++) begin
                            if (r_ci == 2'(i)) begin
                                r_q[i] <= neg_ci ? (QB'(0) - qnext) : qnext;
                            end
                        end
                        if (r_ci == 2'd2) begin
                            r_state <= S_DONE;
                        end else begin
                            r_ci    <= r_ci + 1'b1;
                            r_state <= S_DLD;
                        end
                    end else begin
                        r_bc <= r_bc - 1'b1;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hdl/lam_back.sv
module lam_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_empty,
    input  lam_pkg::t_job             i_job,
    output logic                      o_pop,
    output logic                      o_nstart,
    output logic [2:0][63:0]          o_nv,
    input  lam_pkg::t_norm_sts        i_nsts,
    input  logic [2:0][FRAC_BITS+1:0] i_nq,
    output logic                      o_res_strobe,
    output lam_pkg::t_out_item        o_res
);

    localparam int AX = FRAC_BITS + 2;
    localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_NF, S_RC, S_NR, S_UP, S_TR, S_OUT
    } t_state;

    t_state             r_state;
    logic [2:0][31:0]   r_eye;
    logic [2:0][31:0]   r_up;
    logic [2:0][AX-1:0] r_f;
    logic [2:0][AX-1:0] r_r;
    logic [2:0][AX-1:0] r_u;
    logic [2:0][31:0]   r_t;
    logic [2:0][63:0]   r_acc;
    logic               r_degen;
    logic [1:0]         r_row;
    logic [1:0]         r_k;
    logic [1:0]         r_i;
    logic               r_iss;
    logic               r_pv;
    logic [1:0]         r_pk;
    logic               r_pneg;
    logic [63:0]        r_prod;
    logic               r_nstart;
    logic               r_strobe;
    lam_pkg::t_out_item r_res;

    logic [1:0]         ka;
    logic [1:0]         kb;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] mul_p;
    logic               minus;
    logic [1:0]         last_i;
    logic               ph_done;
    logic [2:0][AX-1:0] u_next;
    logic [2:0][31:0]   t_next;
    logic [63:0]        rnd [3];
    logic [63:0]        ng  [3];

    function automatic logic [1:0] nx1(input logic [1:0] k);
        return (k == 2'd2) ? 2'd0 : k + 2'd1;
    endfunction

    function automatic logic [1:0] nx2(input logic [1:0] k);
        return (k == 2'd0) ? 2'd2 : k - 2'd1;
    endfunction

    function automatic logic [31:0] sx(input logic [AX-1:0] v);
        return {{(32 - AX){v[AX-1]}}, v};
    endfunction

    function automatic logic [AX-1:0] pick_ax(input logic [2:0][AX-1:0] v,
                                              input logic [1:0] idx);
        logic [AX-1:0] o;
        unique case (idx)
            2'd0:    o = v[0];
            2'd1:    o = v[1];
            2'd2:    o = v[2];
            default: o = '0;
        endcase
        return o;
    endfunction

    function automatic logic [31:0] pick_w(input logic [2:0][31:0] v,
                                           input logic [1:0] idx);
        logic [31:0] o;
        unique case (idx)
            2'd0:    o = v[0];
            2'd1:    o = v[1];
            2'd2:    o = v[2];
            default: o = '0;
        endcase
        return o;
    endfunction

    // operand select for the shared multiplier
    always_comb begin
        ka     = r_i[0] ? nx2(r_k) : nx1(r_k);
        kb     = r_i[0] ? nx1(r_k) : nx2(r_k);
        minus  = (r_state != S_TR) && r_i[0];
        last_i = (r_state == S_TR) ? 2'd2 : 2'd1;
        unique case (r_state)
            S_RC: begin
                mul_a = $signed(pick_w(r_up, ka));
                mul_b = $signed(sx(pick_ax(r_f, kb)));
            end
            S_UP: begin
                mul_a = $signed(sx(pick_ax(r_f, ka)));
                mul_b = $signed(sx(pick_ax(r_r, kb)));
            end
            default: begin
                unique case (r_k)
                    2'd0:    mul_a = $signed(sx(pick_ax(r_r, r_i)));
                    2'd1:    mul_a = $signed(sx(pick_ax(r_u, r_i)));
                    default: mul_a = $signed(sx(pick_ax(r_f, r_i)));
                endcase
                mul_b = $signed(pick_w(r_eye, r_i));
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign ph_done = !r_iss && !r_pv;

    // round half up to FRAC_BITS, then negate and clamp for translation
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rnd[k]    = 64'($signed(r_acc[k] + HALF) >>> FRAC_BITS);
            u_next[k] = rnd[k][AX-1:0];
            ng[k]     = 64'd0 - rnd[k];
            priority if ($signed(ng[k]) > lam_pkg::SAT_MAX) begin
                t_next[k] = lam_pkg::SAT_MAX[31:0];
            end else if ($signed(ng[k]) < lam_pkg::SAT_MIN) begin
                t_next[k] = lam_pkg::SAT_MIN[31:0];
            end else begin
                t_next[k] = ng[k][31:0];
            end
        end
    end

    assign o_pop        = (r_state == S_IDLE) && !i_empty;
    assign o_nstart     = r_nstart;
    assign o_nv         = r_acc;
    assign o_res_strobe = r_strobe;
    assign o_res        = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_nstart <= 1'b0;
            r_iss    <= 1'b0;
            r_pv     <= 1'b0;
        end else begin
            r_nstart <= 1'b0;
            r_strobe <= 1'b0;

            if (r_pv) begin
                for (int j = 0; j < 3; j++) begin
                    if (r_pk == 2'(j)) begin
                        r_acc[j] <= r_acc[j] + (r_pneg ? (64'd0 - r_prod) : r_prod);
                    end
                end
            end

            if (r_iss) begin
                r_prod <= mul_p;
                r_pk   <= r_k;
                r_pneg <= minus;
                r_pv   <= 1'b1;
                if (r_i == last_i) begin
                    r_i <= '0;
                    if (r_k == 2'd2) begin
                        r_iss <= 1'b0;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end else begin
                r_pv <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_eye   <= i_job.eye;
                        r_up    <= i_job.up;
                        r_degen <= i_job.dir_zero;
                        for (int j = 0; j < 3; j++) begin
                            r_acc[j] <= {{31{i_job.dir[j][32]}}, i_job.dir[j]};
                        end
                        if (i_job.dir_zero) begin
                            r_row   <= lam_pkg::ROW_FIRST;
                            r_state <= S_OUT;
                        end else begin
                            r_nstart <= 1'b1;
                            r_state  <= S_NF;
                        end
                    end
                end
                S_NF: begin
                    if (i_nsts.done) begin
                        if (i_nsts.zero) begin
                            r_degen <= 1'b1;
                            r_row   <= lam_pkg::ROW_FIRST;
                            r_state <= S_OUT;
                        end else begin
                            r_f     <= i_nq;
                            r_acc   <= '0;
                            r_k     <= '0;
                            r_i     <= '0;
                            r_iss   <= 1'b1;
                            r_state <= S_RC;
                        end
                    end
                end
                S_RC: begin
                    if (ph_done) begin
                        r_nstart <= 1'b1;
                        r_state  <= S_NR;
                    end
                end
                S_NR: begin
                    if (i_nsts.done) begin
                        if (i_nsts.zero) begin
                            r_degen <= 1'b1;
                            r_row   <= lam_pkg::ROW_FIRST;
                            r_state <= S_OUT;
                        end else begin
                            r_r     <= i_nq;
                            r_acc   <= '0;
                            r_k     <= '0;
                            r_i     <= '0;
                            r_iss   <= 1'b1;
                            r_state <= S_UP;
                        end
                    end
                end
                S_UP: begin
                    if (ph_done) begin
                        r_u     <= u_next;
                        r_acc   <= '0;
                        r_k     <= '0;
                        r_i     <= '0;
                        r_iss   <= 1'b1;
                        r_state <= S_TR;
                    end
                end
                S_TR: begin
                    if (ph_done) begin
                        r_t     <= t_next;
                        r_row   <= lam_pkg::ROW_FIRST;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_strobe         <= 1'b1;
                    r_res.row_index  <= r_row;
                    r_res.degenerate <= r_degen;
                    r_res.last_row   <= (r_row == lam_pkg::ROW_TRANS);
                    priority if (r_degen) begin
                        r_res.elem_first  <= '0;
                        r_res.elem_second <= '0;
                        r_res.elem_third  <= '0;
                    end else if (r_row == lam_pkg::ROW_TRANS) begin
                        r_res.elem_first  <= r_t[0];
                        r_res.elem_second <= r_t[1];
                        r_res.elem_third  <= r_t[2];
                    end else begin
                        r_res.elem_first  <= sx(pick_ax(r_r, r_row));
                        r_res.elem_second <= sx(pick_ax(r_u, r_row));
                        r_res.elem_third  <= sx(pick_ax(r_f, r_row));
                    end
                    if (r_row == lam_pkg::ROW_TRANS) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_row <= r_row + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hdl/lam_checker.sv
`include "look_at_view_matrix_top_assert.svh"

module lam_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_res_strobe,
    input lam_pkg::t_out_item o_res
);

    // last_row marks exactly the translation row
    `LAM_ASSERT_IMP(a_last_row, i_clk, i_rst_n, o_res_strobe, (o_res.last_row == (o_res.row_index == lam_pkg::ROW_TRANS)))

    // rows of one matrix come back to back in order
    `LAM_ASSERT_NXT(a_row_seq, i_clk, i_rst_n, o_res_strobe && !o_res.last_row, o_res_strobe && (o_res.row_index == $past(o_res.row_index) + 2'd1))

    // a matrix starts at row 0
    `LAM_ASSERT_IMP(a_row_start, i_clk, i_rst_n, o_res_strobe && !$past(o_res_strobe), o_res.row_index == lam_pkg::ROW_FIRST)

    // degenerate rows are all zero
    `LAM_ASSERT_IMP(a_degen_zero, i_clk, i_rst_n, o_res_strobe && o_res.degenerate, (o_res.elem_first == '0) && (o_res.elem_second == '0) && (o_res.elem_third == '0))

    // degenerate holds across one matrix
    `LAM_ASSERT_NXT(a_degen_hold, i_clk, i_rst_n, o_res_strobe && !o_res.last_row, o_res.degenerate == $past(o_res.degenerate))

endmodule

bind look_at_view_matrix_top lam_checker u_lam_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_res_strobe (o_res_strobe),
    .o_res        (o_res)
);
